FILE: sv/crc16fr_pkg.sv
// Shared constants, types and the byte-wide CRC-16/MODBUS step of the frame receiver.
`default_nettype none

package crc16fr_pkg;

	localparam int unsigned MAX_FRAME_BYTES = 256;

	localparam int unsigned PAYLOAD_CAP_INT =
		(MAX_FRAME_BYTES > 10) ? (MAX_FRAME_BYTES - 10) : 0;
	localparam logic [15:0] PAYLOAD_CAP = 16'(PAYLOAD_CAP_INT);

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] MAX_PAYLOAD_RST = 8'd246;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_BEGIN  = 2'd0;
	localparam logic [1:0] REG_END    = 2'd1;
	localparam logic [1:0] REG_MAXPAY = 2'd2;

	// result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	// frame status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_CRC = 2'd1;
	localparam logic [1:0] ST_BAD_END = 2'd2;
	localparam logic [1:0] ST_TOO_LONG = 2'd3;

	typedef struct packed {
		logic [15:0] begin_marker;
		logic [15:0] end_marker;
		logic [7:0]  max_payload;
		logic [15:0] begin_crc;   // CRC after both begin marker bytes
	} cfg_t;

	// one byte through the reflected polynomial, bit by bit
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: sv/crc16fr_ifs.sv
// Handshake interfaces for the received byte stream and the result stream.
`default_nettype none

interface crc16fr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crc16fr_result_if;
	logic       valid;
	logic       ready;
	logic       result_kind;
	logic [7:0] payload_byte;
	logic [7:0] frame_type;
	logic [7:0] transaction_id;
	logic [7:0] payload_length;
	logic [1:0] frame_status;

	modport source (output valid, output result_kind, output payload_byte,
		output frame_type, output transaction_id, output payload_length,
		output frame_status, input ready);
	modport sink (input valid, input result_kind, input payload_byte,
		input frame_type, input transaction_id, input payload_length,
		input frame_status, output ready);
endinterface

`default_nettype wire

FILE: sv/crc16_framed_packet_receiver_core.sv
// Top level: marker-delimited frame receiver with CRC-16/MODBUS check.
// A byte taken into the input register is parsed once the result register can advance,
//   and any result it causes sits in the result register until the sink takes it.
// Throughput: one byte per cycle while the result sink keeps up; the CRC step is a byte-wide unrolled update.
// Reset (arst_n low, asynchronous): hunting with an empty marker window, CRC at
//   0xFFFF, both markers zero, payload limit 246, no result pending.
`default_nettype none

module crc16_framed_packet_receiver_core
	import crc16fr_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	// received byte requests
	crc16fr_byte_if.sink      rx,
	// payload and status results
	crc16fr_result_if.source  res,
	// APB configuration port
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready
);

	// Register map (byte address):
	//   0x0 begin marker, high byte arrives first
	//   0x4 end marker, checked after the received CRC
	//   0x8 largest payload length; also capped at MAX_FRAME_BYTES - 10
	// Writes to any other address are dropped and read back as zero.
	cfg_t cfg;

	crc16fr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Parser: hold each request in the input register, advance the frame phase,
	// fold the byte into the running CRC, and load a payload byte or the closing
	// status into the result register. A stalled result holds the input stage
	// only while the input register is occupied; otherwise requests keep flowing.
	crc16fr_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.rx     (rx),
		.res    (res)
	);

endmodule

`default_nettype wire

FILE: sv/crc16fr_cfg.sv
// APB register file: markers, payload limit and the precomputed begin-marker CRC.
`default_nettype none

module crc16fr_cfg
	import crc16fr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	logic [15:0] begin_marker_q;
	logic [15:0] end_marker_q;
	logic [7:0]  max_payload_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			begin_marker_q <= '0;
			end_marker_q   <= '0;
			max_payload_q  <= MAX_PAYLOAD_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_BEGIN:  begin_marker_q <= pwdata[15:0];
				REG_END:    end_marker_q   <= pwdata[15:0];
				REG_MAXPAY: max_payload_q  <= pwdata[7:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_BEGIN:  prdata = {16'h0000, begin_marker_q};
			REG_END:    prdata = {16'h0000, end_marker_q};
			REG_MAXPAY: prdata = {24'h000000, max_payload_q};
			default:    prdata = '0;
		endcase
	end

	assign cfg.begin_marker = begin_marker_q;
	assign cfg.end_marker   = end_marker_q;
	assign cfg.max_payload  = max_payload_q;
	// CRC over both begin marker bytes; follows the marker register directly
	assign cfg.begin_crc    = crc_byte(crc_byte(CRC_INIT, begin_marker_q[15:8]),
		begin_marker_q[7:0]);

endmodule

`default_nettype wire

FILE: sv/crc16fr_parse.sv
// Input register, frame parser with running CRC, and result register.
`default_nettype none

module crc16fr_parse
	import crc16fr_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire cfg_t         cfg,
	crc16fr_byte_if.sink      rx,
	crc16fr_result_if.source  res
);

	typedef enum logic [9:0] {
		PH_HUNT    = 10'b0000000001,
		PH_LEN_HI  = 10'b0000000010,
		PH_LEN_LO  = 10'b0000000100,
		PH_TYPE    = 10'b0000001000,
		PH_TID     = 10'b0000010000,
		PH_PAYLOAD = 10'b0000100000,
		PH_CRC_HI  = 10'b0001000000,
		PH_CRC_LO  = 10'b0010000000,
		PH_END_HI  = 10'b0100000000,
		PH_END_LO  = 10'b1000000000
	} phase_t;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// parser state
	phase_t      phase_q,    phase_d;
	logic [15:0] shift_q,    shift_d;
	logic [1:0]  fill_q,     fill_d;
	logic [7:0]  decl_len_q, decl_len_d;
	logic [7:0]  remain_q,   remain_d;
	logic [7:0]  type_q,     type_d;
	logic [7:0]  tid_q,      tid_d;
	logic [15:0] crc_q,      crc_d;
	logic [15:0] rx_crc_q,   rx_crc_d;
	logic [7:0]  len_hi_q,   len_hi_d;

	// result register
	logic       res_valid_q;
	logic       kind_q;
	logic [7:0] data_q;
	logic [7:0] rtype_q;
	logic [7:0] rtid_q;
	logic [7:0] rlen_q;
	logic [1:0] status_q;

	logic       advance;
	logic       fire;
	logic       emit;
	logic       e_kind;
	logic [7:0] e_data;
	logic [7:0] e_len;
	logic [1:0] e_status;

	logic [15:0] crc_step;
	logic [15:0] hunt_shift;
	logic [1:0]  hunt_fill;
	logic [15:0] len16;
	logic [15:0] limit16;
	logic [15:0] tail;

	assign advance  = !res_valid_q || res.ready;
	assign fire     = valid_s1 && advance;
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign crc_step   = crc_byte(crc_q, byte_s1);
	assign hunt_shift = {shift_q[7:0], byte_s1};
	assign hunt_fill  = (fill_q < 2'd2) ? (fill_q + 2'd1) : fill_q;
	assign len16      = {len_hi_q, byte_s1};
	assign limit16    = ({8'h00, cfg.max_payload} < PAYLOAD_CAP) ?
		{8'h00, cfg.max_payload} : PAYLOAD_CAP;
	assign tail       = {shift_q[15:8], byte_s1};

	always_comb begin
		phase_d    = phase_q;
		shift_d    = shift_q;
		fill_d     = fill_q;
		decl_len_d = decl_len_q;
		remain_d   = remain_q;
		type_d     = type_q;
		tid_d      = tid_q;
		crc_d      = crc_q;
		rx_crc_d   = rx_crc_q;
		len_hi_d   = len_hi_q;
		emit       = 1'b0;
		e_kind     = KIND_PAYLOAD;
		e_data     = 8'h00;
		e_len      = decl_len_q;
		e_status   = ST_OK;

		if (fire) begin
			case (phase_q)
				PH_HUNT: begin
					shift_d = hunt_shift;
					fill_d  = hunt_fill;
					if (hunt_fill == 2'd2 && hunt_shift == cfg.begin_marker) begin
						crc_d      = cfg.begin_crc;
						type_d     = '0;
						tid_d      = '0;
						decl_len_d = '0;
						phase_d    = PH_LEN_HI;
					end
				end
				PH_LEN_HI: begin
					len_hi_d = byte_s1;
					crc_d    = crc_step;
					phase_d  = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					crc_d = crc_step;
					if (len16 > limit16) begin
						// reject at once, saturate the reported length
						type_d   = '0;
						tid_d    = '0;
						phase_d  = PH_HUNT;
						shift_d  = '0;
						fill_d   = '0;
						emit     = 1'b1;
						e_kind   = KIND_STATUS;
						e_len    = (|len16[15:8]) ? 8'hFF : len16[7:0];
						e_status = ST_TOO_LONG;
					end else begin
						decl_len_d = len16[7:0];
						remain_d   = len16[7:0];
						phase_d    = PH_TYPE;
					end
				end
				PH_TYPE: begin
					type_d  = byte_s1;
					crc_d   = crc_step;
					phase_d = PH_TID;
				end
				PH_TID: begin
					tid_d   = byte_s1;
					crc_d   = crc_step;
					phase_d = (remain_q == 8'd0) ? PH_CRC_HI : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					crc_d    = crc_step;
					remain_d = (remain_q > 8'd0) ? (remain_q - 8'd1) : remain_q;
					if (remain_d == 8'd0) begin
						phase_d = PH_CRC_HI;
					end
					emit   = 1'b1;
					e_kind = KIND_PAYLOAD;
					e_data = byte_s1;
				end
				PH_CRC_HI: begin
					rx_crc_d = {byte_s1, 8'h00};
					phase_d  = PH_CRC_LO;
				end
				PH_CRC_LO: begin
					rx_crc_d = {rx_crc_q[15:8], byte_s1};
					phase_d  = PH_END_HI;
				end
				PH_END_HI: begin
					shift_d = {byte_s1, 8'h00};
					phase_d = PH_END_LO;
				end
				PH_END_LO: begin
					emit   = 1'b1;
					e_kind = KIND_STATUS;
					// end marker outranks the CRC check
					if (tail != cfg.end_marker) begin
						e_status = ST_BAD_END;
					end else if (rx_crc_q != crc_q) begin
						e_status = ST_BAD_CRC;
					end else begin
						e_status = ST_OK;
					end
					phase_d = PH_HUNT;
					shift_d = '0;
					fill_d  = '0;
				end
				default: begin
					phase_d = PH_HUNT;
					shift_d = '0;
					fill_d  = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			shift_q    <= '0;
			fill_q     <= '0;
			decl_len_q <= '0;
			remain_q   <= '0;
			type_q     <= '0;
			tid_q      <= '0;
			crc_q      <= CRC_INIT;
			rx_crc_q   <= '0;
			len_hi_q   <= '0;
		end else begin
			phase_q    <= phase_d;
			shift_q    <= shift_d;
			fill_q     <= fill_d;
			decl_len_q <= decl_len_d;
			remain_q   <= remain_d;
			type_q     <= type_d;
			tid_q      <= tid_d;
			crc_q      <= crc_d;
			rx_crc_q   <= rx_crc_d;
			len_hi_q   <= len_hi_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			kind_q   <= e_kind;
			data_q   <= e_data;
			rtype_q  <= type_d;
			rtid_q   <= tid_d;
			rlen_q   <= e_len;
			status_q <= e_status;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.result_kind    = kind_q;
	assign res.payload_byte   = data_q;
	assign res.frame_type     = rtype_q;
	assign res.transaction_id = rtid_q;
	assign res.payload_length = rlen_q;
	assign res.frame_status   = status_q;

endmodule

`default_nettype wire

FILE: tb/sv/crc16_framed_packet_receiver_core_test.sv
// Self-checking testbench for the marker-delimited CRC-16 frame receiver core.
`timescale 1ns / 1ps

module crc16_framed_packet_receiver_core_test;
	import crc16fr_pkg::*;

	localparam int ITEM_TARGET    = 1700;
	localparam int DRAIN_CYCLES   = 8;     // a taken byte is parsed from the input register
	localparam int LONG_HOLD      = 300;   // receiver hold-off that backs up the input
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 40;

	// index past the last register; writes to it must leave everything alone
	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef enum logic [3:0] {
		P_HUNT, P_LEN_HI, P_LEN_LO, P_TYPE, P_TID,
		P_PAYLOAD, P_CRC_HI, P_CRC_LO, P_END_HI, P_END_LO
	} rx_phase_e;

	typedef enum logic [1:0] {FLAW_NONE, FLAW_CRC, FLAW_END, FLAW_BOTH} frame_flaw_e;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic [7:0] ftype;
		logic [7:0] tid;
		logic [7:0] len;
		logic [1:0] status;
	} frame_result_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	wire  [31:0] prdata;
	wire         pready;

	crc16fr_byte_if   rx_bus ();
	crc16fr_result_if res_bus ();

	crc16_framed_packet_receiver_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_bus),
		.res     (res_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// ------------------------------------------------------------------
	// Predictor state: register copies and the parser as the block sees it
	// ------------------------------------------------------------------
	logic [15:0] cfg_begin = 16'h0000;
	logic [15:0] cfg_end   = 16'h0000;
	logic [7:0]  cfg_max   = MAX_PAYLOAD_RST;

	rx_phase_e   rx_phase    = P_HUNT;
	logic [15:0] hunt_window = '0;    // also holds the first end-marker byte
	logic [1:0]  hunt_fill   = '0;
	logic [7:0]  hdr_len     = '0;
	logic [7:0]  bytes_left  = '0;
	logic [7:0]  hdr_type    = '0;
	logic [7:0]  hdr_tid     = '0;
	logic [15:0] run_crc     = CRC_INIT;
	logic [15:0] got_crc     = '0;
	logic [7:0]  len_high    = '0;

	frame_result_t due_results[$];   // results the block still owes, oldest first
	logic [7:0]    link_bytes[$];    // bytes waiting to be offered on the link

	int  bytes_queued  = 0;
	int  bytes_taken   = 0;
	int  frame_bytes   = 0;          // bytes that belong to frames, noise excluded
	int  mismatches    = 0;
	int  idle_cycles   = 0;
	int  gap_left      = 0;
	int  stall_left    = 0;
	int  hold_left     = 0;
	int  hold_requests = 0;
	int  holds_granted = 0;
	bit  rx_took       = 1'b0;
	bit  gaps_on       = 1'b1;
	bit  stalls_on     = 1'b1;

	// CRC-16/MODBUS, one data bit per shift of the reflected register
	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			if (c[0] ^ b[i])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

	// the accepted length is capped by both the register and the frame buffer
	function automatic logic [15:0] payload_limit();
		return ({8'h00, cfg_max} < PAYLOAD_CAP) ? {8'h00, cfg_max} : PAYLOAD_CAP;
	endfunction

	function automatic void restart_hunt();
		rx_phase    = P_HUNT;
		hunt_window = '0;
		hunt_fill   = '0;
	endfunction

	// Advance the parser by one received byte; return 1 when a result falls out.
	function automatic bit parse_rx_byte(input logic [7:0] b, output frame_result_t r);
		logic [15:0] len16;
		logic [15:0] tail;
		r = '0;
		case (rx_phase)
			P_HUNT: begin
				hunt_window = {hunt_window[7:0], b};
				if (hunt_fill < 2)
					hunt_fill++;
				// a match needs a full window since the hunt began
				if (hunt_fill == 2 && hunt_window == cfg_begin) begin
					run_crc  = crc16_step(crc16_step(CRC_INIT, hunt_window[15:8]),
						hunt_window[7:0]);
					hdr_type = '0;
					hdr_tid  = '0;
					hdr_len  = '0;
					rx_phase = P_LEN_HI;
				end
				return 1'b0;
			end
			P_LEN_HI: begin
				len_high = b;
				run_crc  = crc16_step(run_crc, b);
				rx_phase = P_LEN_LO;
				return 1'b0;
			end
			P_LEN_LO: begin
				run_crc = crc16_step(run_crc, b);
				len16   = {len_high, b};
				if (len16 > payload_limit()) begin
					// reject at once, header fields blanked, length saturated
					hdr_type = '0;
					hdr_tid  = '0;
					restart_hunt();
					r.kind   = KIND_STATUS;
					r.len    = (len16 > 16'd255) ? 8'hFF : len16[7:0];
					r.status = ST_TOO_LONG;
					return 1'b1;
				end
				hdr_len    = len16[7:0];
				bytes_left = len16[7:0];
				rx_phase   = P_TYPE;
				return 1'b0;
			end
			P_TYPE: begin
				hdr_type = b;
				run_crc  = crc16_step(run_crc, b);
				rx_phase = P_TID;
				return 1'b0;
			end
			P_TID: begin
				hdr_tid  = b;
				run_crc  = crc16_step(run_crc, b);
				// an empty payload goes straight to the CRC
				rx_phase = (bytes_left == 0) ? P_CRC_HI : P_PAYLOAD;
				return 1'b0;
			end
			P_PAYLOAD: begin
				run_crc = crc16_step(run_crc, b);
				if (bytes_left > 0)
					bytes_left--;
				if (bytes_left == 0)
					rx_phase = P_CRC_HI;
				r.kind   = KIND_PAYLOAD;
				r.data   = b;
				r.ftype  = hdr_type;
				r.tid    = hdr_tid;
				r.len    = hdr_len;
				r.status = ST_OK;
				return 1'b1;
			end
			P_CRC_HI: begin
				got_crc  = {b, 8'h00};
				rx_phase = P_CRC_LO;
				return 1'b0;
			end
			P_CRC_LO: begin
				got_crc[7:0] = b;
				rx_phase     = P_END_HI;
				return 1'b0;
			end
			P_END_HI: begin
				hunt_window = {b, 8'h00};
				rx_phase    = P_END_LO;
				return 1'b0;
			end
			P_END_LO: begin
				tail = {hunt_window[15:8], b};
				// a bad end marker outranks a bad CRC
				if (tail != cfg_end)
					r.status = ST_BAD_END;
				else if (got_crc != run_crc)
					r.status = ST_BAD_CRC;
				else
					r.status = ST_OK;
				restart_hunt();
				r.kind  = KIND_STATUS;
				r.ftype = hdr_type;
				r.tid   = hdr_tid;
				r.len   = hdr_len;
				return 1'b1;
			end
			default: begin
				restart_hunt();
				return 1'b0;
			end
		endcase
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatches++;
		// keep the log bounded when the block is badly off
		if (mismatches <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// mostly short gaps, now and then a long one, none at all when switched off
	function automatic int draw_gap(input bit enabled);
		int r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Byte sender: offer the next queued byte at the falling edge, hold it
	// until it is taken, then maybe idle for a while.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			rx_bus.valid <= 1'b0;
		end else if (!rx_bus.valid || rx_took) begin
			rx_took = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				rx_bus.valid <= 1'b0;
			end else if (link_bytes.size() != 0) begin
				rx_bus.rx_byte <= link_bytes.pop_front();
				rx_bus.valid   <= 1'b1;
				gap_left = draw_gap(gaps_on);
			end else begin
				rx_bus.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result receiver: random stalls, plus the long hold-off on request so
	// that the result register stays full and the block backs up its input.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			res_bus.ready <= 1'b0;
		end else if (hold_requests != holds_granted) begin
			holds_granted++;
			hold_left = LONG_HOLD;
			res_bus.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			res_bus.ready <= 1'b0;
		end else begin
			res_bus.ready <= 1'b1;
			if (stalls_on && $urandom_range(0, 3) == 0)
				stall_left = draw_gap(1'b1);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: sample both handshakes at the rising edge, check results
	// against the oldest due one, predict from each accepted byte, and keep
	// the watchdog going.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		frame_result_t fresh;
		frame_result_t want;
		bit            moved;
		if (arst_n) begin
			moved = 1'b0;
			// check before predicting: a byte cannot produce its result at the
			// edge that takes it
			if (res_bus.valid && res_bus.ready) begin
				moved = 1'b1;
				if (due_results.size() == 0) begin
					flag_mismatch($sformatf("unexpected result kind %0d byte %0h status %0d",
						res_bus.result_kind, res_bus.payload_byte, res_bus.frame_status));
				end else begin
					want = due_results.pop_front();
					check_field("result_kind", {7'd0, res_bus.result_kind}, {7'd0, want.kind});
					check_field("payload_byte", res_bus.payload_byte, want.data);
					check_field("frame_type", res_bus.frame_type, want.ftype);
					check_field("transaction_id", res_bus.transaction_id, want.tid);
					check_field("payload_length", res_bus.payload_length, want.len);
					check_field("frame_status", {6'd0, res_bus.frame_status},
						{6'd0, want.status});
				end
			end
			if (rx_bus.valid && rx_bus.ready) begin
				moved = 1'b1;
				rx_took = 1'b1;
				bytes_taken++;
				if (parse_rx_byte(rx_bus.rx_byte, fresh))
					due_results.push_back(fresh);
			end
			if (psel && penable && pwrite && pready)
				moved = 1'b1;
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("crc16_framed_packet_receiver_core regression: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_byte(input logic [7:0] b);
		link_bytes.push_back(b);
		bytes_queued++;
	endtask

	// wait until every byte is taken and every result seen, then a little more
	task automatic settle();
		do @(negedge clk);
		while (bytes_taken != bytes_queued || due_results.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// feed filler until the parser is hunting again, so registers change only
	// between frames
	task automatic return_to_hunt();
		settle();
		while (rx_phase != P_HUNT) begin
			queue_byte(8'($urandom_range(0, 255)));
			settle();
		end
	endtask

	// APB write: setup cycle, access cycle, then drop the select
	task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk);
		while (pready !== 1'b1);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		case (idx)
			REG_BEGIN:  cfg_begin = value[15:0];
			REG_END:    cfg_end   = value[15:0];
			REG_MAXPAY: cfg_max   = value[7:0];
			default:    ;
		endcase
	endtask

	// Build one frame under the current markers and queue its first cut bytes
	// (all of them when cut is negative). Over-long headers stop after the length.
	task automatic queue_frame(input logic [15:0] len16, input logic [7:0] ftype,
		input logic [7:0] tid, input frame_flaw_e flaw, input int cut);
		logic [7:0]  img[$];
		logic [15:0] crc;
		logic [15:0] tail;
		int          keep;
		img.push_back(cfg_begin[15:8]);
		img.push_back(cfg_begin[7:0]);
		img.push_back(len16[15:8]);
		img.push_back(len16[7:0]);
		if (len16 <= payload_limit()) begin
			img.push_back(ftype);
			img.push_back(tid);
			repeat (len16) img.push_back(8'($urandom_range(0, 255)));
			crc = CRC_INIT;
			foreach (img[k])
				crc = crc16_step(crc, img[k]);
			if (flaw == FLAW_CRC || flaw == FLAW_BOTH)
				crc ^= 16'($urandom_range(1, 16'hFFFF));
			tail = cfg_end;
			if (flaw == FLAW_END || flaw == FLAW_BOTH)
				tail ^= 16'($urandom_range(1, 16'hFFFF));
			img.push_back(crc[15:8]);
			img.push_back(crc[7:0]);
			img.push_back(tail[15:8]);
			img.push_back(tail[7:0]);
		end
		keep = (cut >= 0 && cut < img.size()) ? cut : img.size();
		for (int k = 0; k < keep; k++)
			queue_byte(img[k]);
		frame_bytes += keep;
	endtask

	// line noise, now and then salted with the marker's first byte
	task automatic queue_noise(input int n);
		repeat (n) begin
			if ($urandom_range(0, 3) == 0)
				queue_byte(cfg_begin[15:8]);
			else
				queue_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// mostly short payloads, some at the limit, a few wild lengths
	function automatic logic [15:0] draw_length();
		logic [15:0] lim;
		int          r;
		int          v;
		lim = payload_limit();
		r   = $urandom_range(0, 99);
		if (r < 45)
			return 16'($urandom_range(0, (lim < 8) ? lim : 8));
		if (r < 85)
			return 16'($urandom_range(0, (lim < 24) ? lim : 24));
		if (r < 95) begin
			v = int'(lim) - 1 + $urandom_range(0, 3);
			return 16'((v < 0) ? 0 : v);
		end
		return 16'($urandom_range(0, 16'hFFFF));
	endfunction

	function automatic frame_flaw_e draw_flaw();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return FLAW_NONE;
		if (r < 77)
			return FLAW_CRC;
		if (r < 89)
			return FLAW_END;
		return FLAW_BOTH;
	endfunction

	function automatic logic [15:0] draw_marker();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'h0000;
		if (r == 1)
			return 16'hFFFF;
		return 16'($urandom_range(0, 16'hFFFF));
	endfunction

	function automatic logic [7:0] draw_max_payload();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 8'($urandom_range(0, 3));
		if (r < 70)
			return 8'($urandom_range(4, 24));
		if (r < 90)
			return 8'($urandom_range(25, 60));
		return ($urandom_range(0, 1) != 0) ? MAX_PAYLOAD_RST : 8'($urandom_range(0, 246));
	endfunction

	// one random setting and a burst of traffic under it
	task automatic run_random_phase();
		int r;
		return_to_hunt();
		if ($urandom_range(0, 2) != 0)
			write_register(REG_BEGIN, {16'h0000, draw_marker()});
		if ($urandom_range(0, 2) != 0)
			write_register(REG_END, ($urandom_range(0, 4) == 0) ? {16'h0000, cfg_begin}
				: {16'h0000, draw_marker()});
		if ($urandom_range(0, 2) != 0)
			write_register(REG_MAXPAY, {24'h000000, draw_max_payload()});
		gaps_on   = ($urandom_range(0, 4) != 0);
		stalls_on = ($urandom_range(0, 4) != 0);
		repeat ($urandom_range(3, 10)) begin
			r = $urandom_range(0, 99);
			if (r < 72)
				queue_frame(draw_length(), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), draw_flaw(), -1);
			else if (r < 80)
				queue_frame(16'($urandom_range(int'(payload_limit()) + 1, 16'hFFFF)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), FLAW_NONE, -1);
			else if (r < 88)
				queue_frame(draw_length(), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), FLAW_NONE, $urandom_range(1, 30));
			else
				queue_noise($urandom_range(1, 6));
		end
		settle();
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		rx_bus.valid   = 1'b0;
		rx_bus.rx_byte = '0;
		res_bus.ready  = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames under the reset settings (zero markers, limit 246).
		// Empty payload: its lone leading zero must not match a half-filled window.
		queue_frame(16'd0, 8'hFF, 8'h00, FLAW_NONE, -1);
		// length above the limit: saturated length, blank header fields
		queue_frame(16'h0100, 8'h00, 8'h00, FLAW_NONE, -1);
		// CRC and end marker both wrong: the end marker is reported
		queue_frame(16'd1, 8'h7F, 8'h80, FLAW_BOTH, -1);
		settle();

		// All-ones markers and a zero limit; the spare index must change nothing.
		return_to_hunt();
		write_register(REG_SPARE, $urandom());
		write_register(REG_BEGIN, 32'h0000_FFFF);
		write_register(REG_END, 32'h0000_FFFF);
		write_register(REG_MAXPAY, 32'h0000_0000);
		queue_frame(16'd0, 8'hA5, 8'h5A, FLAW_NONE, -1);
		queue_frame(16'd0, 8'h00, 8'hFF, FLAW_CRC, -1);
		queue_frame(16'd1, 8'h00, 8'h00, FLAW_NONE, -1);
		queue_frame(16'hFFFF, 8'h00, 8'h00, FLAW_NONE, -1);
		queue_noise(3);
		queue_frame(16'd0, 8'h11, 8'h22, FLAW_END, -1);
		settle();

		// Zero markers, full limit: long frames while the receiver holds off.
		return_to_hunt();
		write_register(REG_BEGIN, 32'h0000_0000);
		write_register(REG_END, 32'h0000_0000);
		write_register(REG_MAXPAY, {24'h000000, MAX_PAYLOAD_RST});
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		hold_requests++;
		queue_frame(16'd200, 8'h3C, 8'hC3, FLAW_NONE, -1);
		queue_frame(16'd246, 8'hFF, 8'hFF, FLAW_CRC, -1);
		queue_frame(16'd247, 8'h00, 8'h00, FLAW_NONE, -1);
		queue_frame(16'd5, 8'h01, 8'h02, FLAW_END, -1);
		settle();

		while (frame_bytes < ITEM_TARGET)
			run_random_phase();

		settle();
		if (due_results.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", due_results.size()));
		if (mismatches == 0)
			$display("crc16_framed_packet_receiver_core regression: pass");
		else
			$display("crc16_framed_packet_receiver_core regression: fail");
		$finish;
	end

endmodule
